### sv/fixed_point_mul_div_unit_core_assert.svh
// Assertion macros for the fixed-point multiply/divide unit.
`ifndef FIXED_POINT_MUL_DIV_UNIT_CORE_ASSERT_SVH
`define FIXED_POINT_MUL_DIV_UNIT_CORE_ASSERT_SVH

// same-cycle implication, idle during reset
`define FPMD_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fpmd assertion failed");

// next-cycle implication, idle during reset
`define FPMD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fpmd assertion failed");

`endif

### sv/fpmd_pkg.sv
// ----------------------------------------------------------------------------
// fpmd_pkg
// Types and constants shared by the fixed-point multiply/divide unit.
// ----------------------------------------------------------------------------
package fpmd_pkg;

   localparam int QUOT_W    = 40;  // |a| * 2^8 with |a| up to 2^31
   localparam int REM_W     = 32;
   localparam int MAG_W     = 32;
   localparam int PROD_W    = 64;
   localparam int WIDE_FRAC = 8;   // Q24.8
   localparam int RECIP_EXP_NARROW = 8;   // 2^(8+s)
   localparam int RECIP_EXP_WIDE   = 16;  // 2^16

   localparam logic [1:0] CMD_MUL   = 2'd0;
   localparam logic [1:0] CMD_DIV   = 2'd1;
   localparam logic [1:0] CMD_RECIP = 2'd2;
   localparam logic [1:0] CMD_RSVD  = 2'd3;  // no operation, result 0

   typedef struct packed {
      logic              valid;
      logic [1:0]        cmd;
      logic              wide;
      logic [3:0]        shift;   // scaling shift for multiply
      logic              neg;
      logic              dz;
      logic [MAG_W-1:0]  a_mag;
      logic [MAG_W-1:0]  b_mag;
      logic [QUOT_W-1:0] num;
   } prep_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        cmd;
      logic              wide;
      logic              neg;
      logic              dz;
      logic [31:0]       mres;    // low bits of scaled product magnitude
      logic [REM_W-1:0]  rem;
      logic [QUOT_W-1:0] nq;      // numerator bits shifting out, quotient in
      logic [MAG_W-1:0]  den;
   } div_type;

endpackage

### sv/fpmd_if.sv
// ----------------------------------------------------------------------------
// fpmd_req_if / fpmd_rsp_if
// Valid/ready channels for operation requests and results.
// ----------------------------------------------------------------------------
interface fpmd_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic               wide_mode;
   logic [3:0]         frac_bits;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;

   modport source (output valid, command, wide_mode, frac_bits, operand_a, operand_b,
                   input ready);
   modport sink   (input valid, command, wide_mode, frac_bits, operand_a, operand_b,
                   output ready);
endinterface

interface fpmd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result;
   logic               divide_by_zero;

   modport source (output valid, result, divide_by_zero, input ready);
   modport sink   (input valid, result, divide_by_zero, output ready);
endinterface

### sv/fpmd_prep.sv
// ----------------------------------------------------------------------------
// fpmd_prep
// Operand conditioning: sign split, magnitudes, dividend and zero check.
// ----------------------------------------------------------------------------
module fpmd_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [1:0]        command,
   input  logic              wide_mode,
   input  logic [3:0]        frac_bits,
   input  logic [31:0]       operand_a,
   input  logic [31:0]       operand_b,
   output fpmd_pkg::prep_type out
);
   import fpmd_pkg::*;

   prep_type    stage_ff, stage_in;
   logic [31:0] a_ext, b_ext;
   logic        sa, sb;
   logic [3:0]  sh;
   logic [4:0]  rexp;

   always_comb begin
      a_ext = wide_mode ? operand_a : {{16{operand_a[15]}}, operand_a[15:0]};
      b_ext = wide_mode ? operand_b : {{16{operand_b[15]}}, operand_b[15:0]};
      sa    = a_ext[31];
      sb    = b_ext[31];
      sh    = wide_mode ? 4'(WIDE_FRAC) : frac_bits;
      rexp  = wide_mode ? 5'(RECIP_EXP_WIDE) : 5'(RECIP_EXP_NARROW) + {1'b0, frac_bits};

      stage_in.valid = in_valid;
      stage_in.cmd   = command;
      stage_in.wide  = wide_mode;
      stage_in.shift = sh;
      stage_in.a_mag = sa ? (~a_ext + 32'd1) : a_ext;
      stage_in.b_mag = sb ? (~b_ext + 32'd1) : b_ext;
      stage_in.neg   = (command == CMD_RECIP) ? sb : (sa ^ sb);
      stage_in.dz    = ((command == CMD_DIV) || (command == CMD_RECIP)) && (b_ext == 32'd0);
      if (command == CMD_RECIP) begin
         stage_in.num = QUOT_W'(1) << rexp;
      end else begin
         stage_in.num = QUOT_W'(stage_in.a_mag) << sh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out = stage_ff;
endmodule

### sv/fpmd_mul.sv
// ----------------------------------------------------------------------------
// fpmd_mul
// Two-stage magnitude multiply and scaling shift; seeds the divider state.
// ----------------------------------------------------------------------------
module fpmd_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  fpmd_pkg::prep_type in,
   output fpmd_pkg::div_type  out
);
   import fpmd_pkg::*;

   prep_type          hold_ff;
   logic [PROD_W-1:0] prod_ff, prod_in;
   div_type           stage_ff, stage_in;
   logic [PROD_W-1:0] scaled;

   assign prod_in = PROD_W'(in.a_mag) * PROD_W'(in.b_mag);

   always_comb begin
      scaled         = prod_ff >> hold_ff.shift;  // magnitude shift = truncate toward zero
      stage_in.valid = hold_ff.valid;
      stage_in.cmd   = hold_ff.cmd;
      stage_in.wide  = hold_ff.wide;
      stage_in.neg   = hold_ff.neg;
      stage_in.dz    = hold_ff.dz;
      stage_in.mres  = scaled[31:0];
      stage_in.rem   = '0;
      stage_in.nq    = hold_ff.num;
      stage_in.den   = hold_ff.b_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= '0;
         stage_ff <= '0;
      end else if (en) begin
         hold_ff  <= in;
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign out = stage_ff;
endmodule

### sv/fpmd_div_stage.sv
// ----------------------------------------------------------------------------
// fpmd_div_stage
// One restoring-division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpmd_div_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  fpmd_pkg::div_type in,
   output fpmd_pkg::div_type out
);
   import fpmd_pkg::*;

   div_type          stage_ff, stage_in;
   logic [REM_W:0]   part;
   logic [REM_W+1:0] diff;
   logic             ge;

   always_comb begin
      part     = {in.rem, in.nq[QUOT_W-1]};
      diff     = {1'b0, part} - {2'b00, in.den};
      ge       = ~diff[REM_W+1];
      stage_in = in;
      stage_in.rem = ge ? diff[REM_W-1:0] : part[REM_W-1:0];
      stage_in.nq  = {in.nq[QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign out = stage_ff;
endmodule

### sv/fpmd_out.sv
// ----------------------------------------------------------------------------
// fpmd_out
// Sign restore, width wrap and the result register.
// ----------------------------------------------------------------------------
module fpmd_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  fpmd_pkg::div_type in,
   output logic              out_valid,
   output logic [31:0]       out_result,
   output logic              out_dz
);
   import fpmd_pkg::*;

   logic        valid_ff;
   logic [31:0] result_ff, result_in;
   logic        dz_ff, dz_in;
   logic [31:0] mag, sgn;

   always_comb begin
      mag = (in.cmd == CMD_MUL) ? in.mres : in.nq[31:0];
      sgn = in.neg ? (~mag + 32'd1) : mag;
      if (!in.wide) begin
         sgn = {{16{sgn[15]}}, sgn[15:0]};
      end
      dz_in = in.dz;
      case (in.cmd)
         CMD_MUL:   result_in = sgn;
         CMD_DIV,
         CMD_RECIP: result_in = in.dz ? 32'd0 : sgn;
         default:   result_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
         dz_ff     <= dz_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;
   assign out_dz     = dz_ff;
endmodule

### sv/fixed_point_mul_div_unit_core.sv
// ----------------------------------------------------------------------------
// fixed_point_mul_div_unit_core
// Signed Q-format multiply, divide and reciprocal, fully pipelined.
// ----------------------------------------------------------------------------
// Channel    Direction  Moves
// req_chan   in         command, wide_mode, frac_bits, operand_a, operand_b
// rsp_chan   out        result, divide_by_zero
//
// One transfer per cycle in each direction unless the result side stalls; the stages
// are operand prep, two multiply stages, 40 one-bit divider stages, result register.
// Every item walks the same 44 registers; the 40-step divider sets the depth.
// The whole pipeline holds while the result register is full and not taken.
// Reset (synchronous) clears all valid bits; no clearing sweep.
// ----------------------------------------------------------------------------
module fixed_point_mul_div_unit_core (
   input  logic       clock,
   input  logic       reset,
   fpmd_req_if.sink   req_chan,
   fpmd_rsp_if.source rsp_chan
);
   import fpmd_pkg::*;

   logic     en;
   prep_type prep_q;
   div_type  chain [0:QUOT_W];

   assign en             = ~rsp_chan.valid | rsp_chan.ready;
   assign req_chan.ready = en;

   fpmd_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .command   (req_chan.command),
      .wide_mode (req_chan.wide_mode),
      .frac_bits (req_chan.frac_bits),
      .operand_a (req_chan.operand_a),
      .operand_b (req_chan.operand_b),
      .out       (prep_q)
   );

   fpmd_mul u_mul (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in    (prep_q),
      .out   (chain[0])
   );

   for (genvar i = 0; i < QUOT_W; i++) begin : g_div
      fpmd_div_stage u_stage (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .in    (chain[i]),
         .out   (chain[i+1])
      );
   end

   fpmd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in         (chain[QUOT_W]),
      .out_valid  (rsp_chan.valid),
      .out_result (rsp_chan.result),
      .out_dz     (rsp_chan.divide_by_zero)
   );
endmodule

### sv/fpmd_checker.sv
// ----------------------------------------------------------------------------
// fpmd_port_checker
// Port-level checks on the multiply/divide unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_point_mul_div_unit_core_assert.svh"

module fpmd_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result,
   input logic        rsp_dz
);
   `FPMD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `FPMD_ASSERT_NOW(a_dz_zero, rsp_valid && rsp_dz, rsp_result == 32'd0)
   `FPMD_ASSERT_NOW(a_empty_ready, !rsp_valid, req_ready)
   `FPMD_ASSERT_NOW(a_stall_blocks, rsp_valid && !rsp_ready, !req_ready)
endmodule

bind fixed_point_mul_div_unit_core fpmd_port_checker u_fpmd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_result (rsp_chan.result),
   .rsp_dz     (rsp_chan.divide_by_zero)
);

### test/fpmd_checker.sv
// ----------------------------------------------------------------------------
// fpmd_checker
// Watches the request and result channels of the fixed-point multiply/divide
// unit, computes the expected result of every request transfer and compares
// each result transfer against the oldest pending expectation.
// ----------------------------------------------------------------------------
module fpmd_checker (
   input  logic        clock,
   input  logic        reset,
   fpmd_req_if.sink    req_mon,
   fpmd_rsp_if.source  rsp_mon,
   input  logic        drain,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fpmd_pkg::*;

   typedef struct packed {
      logic [31:0] result;
      logic        dz;
   } qresult_type;

   qresult_type expected_q[$];
   int          mismatch_count;

   // Truncating signed division; SV '/' on signed longint truncates toward zero.
   function automatic qresult_type compute_qresult(logic [1:0] cmd, logic wide,
                                                   logic [3:0] s, logic [31:0] a_in,
                                                   logic [31:0] b_in);
      longint a, b, r, num;
      qresult_type q;
      q = '0;
      r = 0;
      if (wide) begin
         a = longint'($signed(a_in));
         b = longint'($signed(b_in));
      end else begin
         a = longint'($signed(a_in[15:0]));
         b = longint'($signed(b_in[15:0]));
      end
      case (cmd)
         CMD_MUL: begin
            r = (a * b) / (wide ? 64'sd256 : (64'sd1 <<< s));
         end
         CMD_DIV, CMD_RECIP: begin
            if (b == 0) begin
               q.dz = 1'b1;
               return q;
            end
            if (cmd == CMD_DIV)
               num = wide ? a * 256 : a * (64'sd1 <<< s);
            else
               num = wide ? 64'sd65536 : (64'sd256 <<< s);
            r = num / b;
         end
         default: return q;
      endcase
      q.result = wide ? r[31:0] : {{16{r[15]}}, r[15:0]};
      return q;
   endfunction

   always @(posedge clock) begin
      qresult_type exp_q;
      if (reset) begin
         expected_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(compute_qresult(req_mon.command, req_mon.wide_mode,
               req_mon.frac_bits, req_mon.operand_a, req_mon.operand_b));
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_count++;
            if (expected_q.size() == 0) begin
               fail_count++;
               if (mismatch_count++ < 10)
                  $display("%0t: unexpected result transfer %h", $realtime,
                           rsp_mon.result);
            end else begin
               exp_q = expected_q.pop_front();
               if (exp_q.result !== rsp_mon.result || exp_q.dz !== rsp_mon.divide_by_zero)
               begin
                  fail_count++;
                  if (mismatch_count++ < 10)
                     $display("%0t: mismatch result exp %h got %h, dz exp %b got %b",
                              $realtime, exp_q.result, rsp_mon.result, exp_q.dz,
                              rsp_mon.divide_by_zero);
               end
            end
         end
      end
      pending_count = expected_q.size();
   end

   always @(posedge drain) begin
      if (expected_q.size() != 0) begin
         fail_count += expected_q.size();
         $display("%0d expected results never arrived", expected_q.size());
      end
   end

   initial begin
      fail_count = 0;
      pending_count = 0;
      result_count = 0;
      mismatch_count = 0;
   end
endmodule

### test/tb_fixed_point_mul_div_unit_core.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_mul_div_unit_core
// Directed corner operations then random mixed-width multiply, divide and
// reciprocal requests plus some reserved commands, with random gaps on both channels
// and a long result-side hold-off that backs the pipeline up to the request side.
// ----------------------------------------------------------------------------
module tb_fixed_point_mul_div_unit_core;
   timeunit 1ns;
   timeprecision 1ps;
   import fpmd_pkg::*;

   localparam int LATENCY = 44;

   logic clock;
   logic reset;
   logic drain;
   int   fail_count, pending_count, result_count;
   int   send_idle_pct, recv_idle_pct;
   int   holdoff_cycles;
   int   sent_count;

   fpmd_req_if req_chan();
   fpmd_rsp_if rsp_chan();

   fixed_point_mul_div_unit_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   fpmd_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan.sink),
      .rsp_mon      (rsp_chan.source),
      .drain        (drain),
      .fail_count   (fail_count),
      .pending_count(pending_count),
      .result_count (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

   // result-side ready: random stalls, or a counted hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (holdoff_cycles > 0) begin
         holdoff_cycles <= holdoff_cycles - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return {{16{1'b1}}, 16'h8000};
         3: return 32'h0000_7fff;
         4: return 32'($signed($urandom_range(8) - 4));
         5: return 32'({$urandom, 16'h0}) | 32'($urandom_range(3));
         default: return $urandom;
      endcase
   endfunction

   // one request transfer; valid stays high across back-to-back items
   task automatic send_req(logic [1:0] cmd, logic wide, logic [3:0] s,
                           logic [31:0] a, logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.command   <= cmd;
      req_chan.wide_mode <= wide;
      req_chan.frac_bits <= s;
      req_chan.operand_a <= a;
      req_chan.operand_b <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_random(int count);
      logic [1:0] cmd;
      for (int i = 0; i < count; i++) begin
         cmd = ($urandom_range(19) == 0) ? CMD_RSVD : 2'($urandom_range(2));
         send_req(cmd, 1'($urandom), 4'($urandom), pick_operand(),
                  ($urandom_range(9) == 0) ? 32'h0 : pick_operand());
      end
   endtask

   initial begin
      int wait_cycles;
      reset = 1'b1;
      drain = 1'b0;
      holdoff_cycles = 0;
      sent_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_chan.valid     = 1'b0;
      req_chan.command   = CMD_MUL;
      req_chan.wide_mode = 1'b0;
      req_chan.frac_bits = '0;
      req_chan.operand_a = '0;
      req_chan.operand_b = '0;
      rsp_chan.ready     = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_req(CMD_MUL,   1'b0, 4'd8,  32'h0000_7fff, 32'h0000_7fff);
      send_req(CMD_MUL,   1'b0, 4'd0,  32'h0000_8000, 32'h0000_8000);
      send_req(CMD_MUL,   1'b0, 4'd15, 32'hffff_8000, 32'h0000_7fff);
      send_req(CMD_MUL,   1'b1, 4'd0,  32'h8000_0000, 32'h8000_0000);
      send_req(CMD_MUL,   1'b1, 4'd3,  32'h7fff_ffff, 32'hffff_ffff);
      send_req(CMD_MUL,   1'b1, 4'd0,  32'hffff_ffff, 32'h0000_0001);
      send_req(CMD_DIV,   1'b0, 4'd8,  32'h0000_0100, 32'h0000_0000);
      send_req(CMD_DIV,   1'b0, 4'd8,  32'h1234_0100, 32'hffff_0000);
      send_req(CMD_DIV,   1'b0, 4'd15, 32'h0000_8000, 32'h0000_ffff);
      send_req(CMD_DIV,   1'b0, 4'd0,  32'h0000_7fff, 32'h0000_0003);
      send_req(CMD_DIV,   1'b1, 4'd0,  32'h8000_0000, 32'hffff_ffff);
      send_req(CMD_DIV,   1'b1, 4'd0,  32'h7fff_ffff, 32'h0000_0001);
      send_req(CMD_DIV,   1'b1, 4'd0,  32'h0000_0005, 32'h0000_0000);
      send_req(CMD_DIV,   1'b1, 4'd0,  32'hffff_fff9, 32'h0000_0002);
      send_req(CMD_RECIP, 1'b0, 4'd0,  32'h1111_1111, 32'h0000_0000);
      send_req(CMD_RECIP, 1'b0, 4'd15, 32'h0000_0000, 32'h0000_0001);
      send_req(CMD_RECIP, 1'b0, 4'd8,  32'hffff_ffff, 32'hffff_ffff);
      send_req(CMD_RECIP, 1'b0, 4'd7,  32'h0000_0000, 32'h0000_8000);
      send_req(CMD_RECIP, 1'b1, 4'd5,  32'h0000_0000, 32'h0000_0000);
      send_req(CMD_RECIP, 1'b1, 4'd0,  32'h0000_0000, 32'h8000_0000);
      send_req(CMD_RECIP, 1'b1, 4'd0,  32'h0000_0000, 32'hffff_fffd);
      send_req(CMD_RSVD,  1'b0, 4'd9,  32'h0000_1234, 32'h0000_0000);
      send_req(CMD_RSVD,  1'b1, 4'd9,  32'hffff_ffff, 32'hffff_ffff);

      // random phases with changing idle mix
      send_idle_pct = 34; recv_idle_pct = 51;
      send_random(120);
      send_idle_pct = 51; recv_idle_pct = 34;
      send_random(120);
      send_idle_pct = 0;  recv_idle_pct = 0;
      holdoff_cycles <= 3 * LATENCY;
      send_random(160);
      req_chan.valid <= 1'b0;

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      drain <= 1'b1;
      @(posedge clock);
      @(posedge clock);
      $display("Sent %0d requests (multiply, divide, reciprocal, both widths), %0d results",
               sent_count, result_count);
      $display("checked with random stalls and a long result-side hold-off");
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
